// File: rtl/core/scms_pkg.sv
package scms_pkg;

    // command codes on s_tuser
    localparam logic CMD_STAMP = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_COVER_SIZE   = 2'd0;
    localparam logic [1:0] REG_ORIGIN_X     = 2'd1;
    localparam logic [1:0] REG_ORIGIN_Y     = 2'd2;
    localparam logic [1:0] REG_SMOOTH_START = 2'd3;

    localparam logic [23:0] COVER_RESET  = 24'd5000;
    localparam logic [7:0]  SMOOTH_RESET = 8'd154;

    // serial divider geometry
    localparam int DIV_DW = 48;
    localparam int DIV_VW = 25;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_TX,
        ST_DIV_TY,
        ST_DIV_RR,
        ST_SETUP,
        ST_TEXEL,
        ST_SQUARE,
        ST_TEST,
        ST_SQRT,
        ST_DIV_Q,
        ST_DIV_V,
        ST_WRITE,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
        logic              rem_nz;
    } div_rsp_t;

endpackage

// File: rtl/core/scms_div.sv
module scms_div import scms_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_VW-1:0] dvs_reg;

    logic [DIV_VW:0]   rem_sh;
    logic [DIV_VW:0]   rem_sub;
    logic              ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DIV_DW-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_DW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
            quo_reg <= {quo_reg[DIV_DW-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_nz   = |rem_reg;

endmodule

// File: rtl/core/soft_circle_min_stamp_unit.sv
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tuser: command; tdata: pos_x pos_y radius read_x read_y
// m_        out  m_tvalid/m_tready  tdata: changed texel_value
// apb       in   psel/penable       cover_size origin_x origin_y smooth_start
//
// one request at a time; a read passes ST_RD_ISSUE, ST_RD_DATA and ST_FINISH
// (ST_IDLE goes straight to ST_FINISH when the texel lies outside the image)
// a stamp first runs three serial divides for the texel mapping, then per texel
// of the box passes ST_TEXEL, ST_SQUARE, ST_TEST and ST_WRITE outside the circle,
// and inside it adds a 26-step square root and one or two divides
// after reset a clearing pass writes 255 to all IMAGE_SIDE*IMAGE_SIDE texels,
// one per cycle, with s_tready low; configuration writes are taken meanwhile
// a finished result waits in the output register while the next request is taken
module soft_circle_min_stamp_unit import scms_pkg::*; #(
    parameter int IMAGE_SIDE = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // pos_x, pos_y, radius, read_x, read_y
    input  logic [0:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // changed, texel_value, zero fill
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int XW     = $clog2(IMAGE_SIDE);
    localparam int DEPTH  = IMAGE_SIDE * IMAGE_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int CENTER = IMAGE_SIDE * 128;

    // ---------------- configuration registers ----------------
    logic [23:0]        cover_reg;
    logic signed [31:0] orgx_reg;
    logic signed [31:0] orgy_reg;
    logic [7:0]         smooth_reg;
    logic [23:0]        cov_eff;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cover_reg  <= COVER_RESET;
            orgx_reg   <= '0;
            orgy_reg   <= '0;
            smooth_reg <= SMOOTH_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_COVER_SIZE:   cover_reg  <= pwdata[23:0];
                REG_ORIGIN_X:     orgx_reg   <= pwdata;
                REG_ORIGIN_Y:     orgy_reg   <= pwdata;
                REG_SMOOTH_START: smooth_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COVER_SIZE:   prdata = {8'd0, cover_reg};
            REG_ORIGIN_X:     prdata = orgx_reg;
            REG_ORIGIN_Y:     prdata = orgy_reg;
            REG_SMOOTH_START: prdata = {24'd0, smooth_reg};
            default:          prdata = '0;
        endcase
    end

    // zero cover size behaves as one
    assign cov_eff = (cover_reg == '0) ? 24'd1 : cover_reg;

    // ---------------- coverage memory ----------------
    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem[addr];
    end

    // ---------------- divider ----------------
    div_req_t div_req;
    div_rsp_t div_rsp;

    scms_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- datapath registers ----------------
    state_t              state_reg, state_next;
    logic                go_reg, go_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic signed [31:0]  px_reg, px_next;
    logic signed [31:0]  py_reg, py_next;
    logic [23:0]         rad_reg, rad_next;
    logic signed [25:0]  tx_reg, tx_next;
    logic signed [25:0]  ty_reg, ty_next;
    logic [24:0]         rr_reg, rr_next;
    logic [49:0]         rr2_reg, rr2_next;
    logic [XW-1:0]       x_reg, x_next;
    logic [XW-1:0]       y_reg, y_next;
    logic [XW-1:0]       x0_reg, x0_next;
    logic [XW-1:0]       x1_reg, x1_next;
    logic [XW-1:0]       y1_reg, y1_next;
    logic [24:0]         ax_reg, ax_next;
    logic [24:0]         ay_reg, ay_next;
    logic [49:0]         sqx_reg, sqx_next;
    logic [49:0]         sqy_reg, sqy_next;
    logic [7:0]          old_reg, old_next;
    logic [51:0]         n_reg, n_next;
    logic [51:0]         res_reg, res_next;
    logic [51:0]         bit_reg, bit_next;
    logic [8:0]          q_reg, q_next;
    logic [7:0]          v_reg, v_next;
    logic                chg_reg, chg_next;
    logic [7:0]          val_reg, val_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_chg_reg, m_chg_next;
    logic [7:0]          m_val_reg, m_val_next;

    // request fields
    logic        cmd;
    logic [31:0] in_pos_x, in_pos_y;
    logic [23:0] in_radius;
    logic [7:0]  in_read_x, in_read_y;

    assign cmd       = s_tuser[0];
    assign in_pos_x  = s_tdata[31:0];
    assign in_pos_y  = s_tdata[63:32];
    assign in_radius = s_tdata[87:64];
    assign in_read_x = s_tdata[95:88];
    assign in_read_y = s_tdata[103:96];

    // world to texel dividend, sign kept apart for floor correction
    logic signed [32:0] wdiff;
    logic signed [44:0] wprod;
    logic [43:0]        wmag;
    logic               wneg;
    logic [49:0]        qmag;
    logic signed [49:0] qsgn;
    logic signed [49:0] tex_val;
    logic signed [25:0] tex_sat;

    always_comb begin
        if (state_reg == ST_DIV_TY) begin
            wdiff = 33'(py_reg) - 33'(orgy_reg);
        end else begin
            wdiff = 33'(px_reg) - 33'(orgx_reg);
        end
        wprod = 45'(wdiff) * 45'(IMAGE_SIDE);
        wneg  = wprod[44];
        wmag  = wneg ? 44'(-wprod) : wprod[43:0];
        qmag  = 50'(div_rsp.quotient) + 50'(wneg && div_rsp.rem_nz);
        qsgn  = wneg ? -$signed(qmag) : $signed(qmag);
        tex_val = qsgn + 50'(CENTER);
        if (tex_val > 50'sd16777216) begin
            tex_sat = 26'sd16777216;
        end else if (tex_val < -50'sd16777216) begin
            tex_sat = -26'sd16777216;
        end else begin
            tex_sat = tex_val[25:0];
        end
    end

    // clamped box edge: floor(v/256) limited to the image
    function automatic logic [XW-1:0] box_edge(input logic signed [26:0] v);
        logic signed [18:0] sh;
        sh = 19'(v >>> 8);
        if (sh < 0) begin
            return '0;
        end else if (sh > 19'(IMAGE_SIDE - 1)) begin
            return XW'(IMAGE_SIDE - 1);
        end else begin
            return sh[XW-1:0];
        end
    endfunction

    // texel offsets from the circle centre
    logic signed [26:0] dx, dy;
    logic [50:0]        d2;
    logic [51:0]        sq_try;
    logic               last_x, last_y;
    logic [8:0]         smooth_ext;

    always_comb begin
        dx = $signed({{(27 - XW - 8){1'b0}}, x_reg, 8'd0}) - 27'(tx_reg);
        dy = $signed({{(27 - XW - 8){1'b0}}, y_reg, 8'd0}) - 27'(ty_reg);
        d2 = 51'(sqx_reg) + 51'(sqy_reg);
        sq_try = res_reg + bit_reg;
        last_x = x_reg == x1_reg;
        last_y = y_reg == y1_reg;
        smooth_ext = {1'b0, smooth_reg};
        addr = AW'(AW'(y_reg) * AW'(IMAGE_SIDE)) + AW'(x_reg);
    end

    // divider operands by step
    always_comb begin
        div_req.start    = go_reg;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            ST_DIV_TX, ST_DIV_TY: begin
                div_req.dividend = DIV_DW'(wmag);
                div_req.divisor  = DIV_VW'(cov_eff);
            end
            ST_DIV_RR: begin
                div_req.dividend = DIV_DW'(36'(rad_reg) * 36'(IMAGE_SIDE));
                div_req.divisor  = DIV_VW'(cov_eff);
            end
            ST_DIV_Q: begin
                div_req.dividend = {res_reg[39:0], 8'd0};
                div_req.divisor  = rr_reg;
            end
            ST_DIV_V: begin
                div_req.dividend = DIV_DW'(16'(q_reg - smooth_ext) * 16'd255);
                div_req.divisor  = DIV_VW'(9'd256 - smooth_ext);
            end
            default: ;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            go_reg       <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            go_reg       <= go_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        rad_reg   <= rad_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        rr_reg    <= rr_next;
        rr2_reg   <= rr2_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        old_reg   <= old_next;
        n_reg     <= n_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        q_reg     <= q_next;
        v_reg     <= v_next;
        chg_reg   <= chg_next;
        val_reg   <= val_next;
        m_chg_reg <= m_chg_next;
        m_val_reg <= m_val_next;
    end

    always_comb begin
        state_next    = state_reg;
        go_next       = 1'b0;
        clr_next      = clr_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        rad_next      = rad_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        rr_next       = rr_reg;
        rr2_next      = rr2_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        sqx_next      = sqx_reg;
        sqy_next      = sqy_reg;
        old_next      = old_reg;
        n_next        = n_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        q_next        = q_reg;
        v_next        = v_reg;
        chg_next      = chg_reg;
        val_next      = val_reg;
        m_tvalid_next = m_tvalid_reg;
        m_chg_next    = m_chg_reg;
        m_val_next    = m_val_reg;
        mem_we        = 1'b0;
        mem_wa        = addr;
        mem_wd        = v_reg;
        s_tready      = 1'b0;

        // output register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = 8'hFF;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    chg_next = 1'b0;
                    val_next = '0;
                    if (cmd == CMD_STAMP) begin
                        px_next    = in_pos_x;
                        py_next    = in_pos_y;
                        rad_next   = in_radius;
                        go_next    = 1'b1;
                        state_next = ST_DIV_TX;
                    end else if (11'(in_read_x) < 11'(IMAGE_SIDE) &&
                                 11'(in_read_y) < 11'(IMAGE_SIDE)) begin
                        x_next     = XW'(in_read_x);
                        y_next     = XW'(in_read_y);
                        state_next = ST_RD_ISSUE;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV_TX: begin
                if (div_rsp.done && !go_reg) begin
                    tx_next    = tex_sat;
                    go_next    = 1'b1;
                    state_next = ST_DIV_TY;
                end
            end
            ST_DIV_TY: begin
                if (div_rsp.done && !go_reg) begin
                    ty_next    = tex_sat;
                    go_next    = 1'b1;
                    state_next = ST_DIV_RR;
                end
            end
            ST_DIV_RR: begin
                if (div_rsp.done && !go_reg) begin
                    if (div_rsp.quotient > 48'd16777216) begin
                        rr_next = 25'd16777216;
                    end else begin
                        rr_next = div_rsp.quotient[24:0];
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                rr2_next   = 50'(rr_reg) * 50'(rr_reg);
                x0_next    = box_edge(27'(tx_reg) - 27'(rr_reg));
                x1_next    = box_edge(27'(tx_reg) + 27'(rr_reg));
                y1_next    = box_edge(27'(ty_reg) + 27'(rr_reg));
                x_next     = box_edge(27'(tx_reg) - 27'(rr_reg));
                y_next     = box_edge(27'(ty_reg) - 27'(rr_reg));
                state_next = ST_TEXEL;
            end
            ST_TEXEL: begin
                // memory read of this texel issued here
                ax_next    = dx[26] ? 25'(-dx) : dx[24:0];
                ay_next    = dy[26] ? 25'(-dy) : dy[24:0];
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                sqx_next   = 50'(ax_reg) * 50'(ax_reg);
                sqy_next   = 50'(ay_reg) * 50'(ay_reg);
                old_next   = mem_q_reg;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (d2 < 51'(rr2_reg)) begin
                    n_next     = 52'(d2);
                    res_next   = '0;
                    bit_next   = 52'd1 << 50;
                    state_next = ST_SQRT;
                end else begin
                    state_next = ST_WRITE;
                    v_next     = 8'hFF;
                end
            end
            ST_SQRT: begin
                if (n_reg >= sq_try) begin
                    n_next   = n_reg - sq_try;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 52'd1) begin
                    go_next    = 1'b1;
                    state_next = ST_DIV_Q;
                end
            end
            ST_DIV_Q: begin
                if (div_rsp.done && !go_reg) begin
                    q_next = div_rsp.quotient[8:0];
                    if (div_rsp.quotient[8:0] <= smooth_ext) begin
                        v_next     = '0;
                        state_next = ST_WRITE;
                    end else begin
                        go_next    = 1'b1;
                        state_next = ST_DIV_V;
                    end
                end
            end
            ST_DIV_V: begin
                if (div_rsp.done && !go_reg) begin
                    v_next = (div_rsp.quotient > 48'd255) ? 8'hFF
                                                          : div_rsp.quotient[7:0];
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // min blend, only lowers
                if (v_reg < old_reg) begin
                    mem_we   = 1'b1;
                    chg_next = 1'b1;
                end
                if (last_x) begin
                    if (last_y) begin
                        state_next = ST_FINISH;
                    end else begin
                        x_next     = x0_reg;
                        y_next     = y_reg + XW'(1);
                        state_next = ST_TEXEL;
                    end
                end else begin
                    x_next     = x_reg + XW'(1);
                    state_next = ST_TEXEL;
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                val_next   = mem_q_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_chg_next    = chg_reg;
                    m_val_next    = val_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_val_reg, m_chg_reg};

endmodule

// File: rtl/core/scms_chk.sv
module scms_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        pready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // clearing pass blocks requests right after reset
    a_clear_block: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !s_tready)
        else $error("request taken during clearing pass");

    // a result is a stamp flag or a texel value, never both
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[8:1] != 8'd0)))
        else $error("changed and texel value both set");

    // fill bits stay zero
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'd0)
        else $error("result fill bits set");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind soft_circle_min_stamp_unit scms_chk u_scms_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
